/* sv/sed_pkg.sv */
// Package for the string escape decoder: character codes, result kinds,
// decoder modes, queue entry types and the escape lookup functions.
// No dependencies.
package sed_pkg;

    localparam logic [7:0] CH_BACKSLASH    = 8'h5C;
    localparam logic [7:0] CH_DQUOTE       = 8'h22;
    localparam logic [7:0] CH_SQUOTE       = 8'h27;
    localparam logic [7:0] CH_QMARK        = 8'h3F;
    localparam logic [7:0] CH_NUL          = 8'h00;
    localparam logic [7:0] CH_ZERO         = 8'h30;
    localparam logic [7:0] CH_SEVEN        = 8'h37;
    localparam logic [7:0] CH_NINE         = 8'h39;
    localparam logic [7:0] CH_UPPER_A      = 8'h41;
    localparam logic [7:0] CH_LOWER_A      = 8'h61;
    localparam logic [7:0] CH_LOWER_Z      = 8'h7A;
    localparam logic [7:0] CH_LOWER_X      = 8'h78;
    localparam logic [7:0] CASE_OFFSET     = 8'h20;
    localparam int         HEX_LETTER_BASE = 10;
    localparam logic [3:0] HEX_ADJ         = 4'(HEX_LETTER_BASE - int'(CH_UPPER_A));
    localparam logic [1:0] OCT_MAX_DIGITS  = 2'd3;
    localparam logic [1:0] HEX_LAST_DIGIT  = 2'd1;

    // Result queue sizing
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_CLOSED = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        MODE_PLAIN = 4'b0001,
        MODE_ESC   = 4'b0010,
        MODE_OCT   = 4'b0100,
        MODE_HEX   = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      kind;
    } t_result;

    // All results caused by one item
    typedef struct packed {
        t_result first;
        logic    has_second;
        t_result second;
    } t_pair;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } t_q_status;

    // {hit, value} for the single-character escapes
    function automatic logic [8:0] simple_escape(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h61:        r = {1'b1, 8'h07};
            8'h62:        r = {1'b1, 8'h08};
            8'h66:        r = {1'b1, 8'h0C};
            8'h6E:        r = {1'b1, 8'h0A};
            8'h72:        r = {1'b1, 8'h0D};
            8'h74:        r = {1'b1, 8'h09};
            8'h76:        r = {1'b1, 8'h0B};
            CH_BACKSLASH: r = {1'b1, CH_BACKSLASH};
            CH_SQUOTE:    r = {1'b1, CH_SQUOTE};
            CH_DQUOTE:    r = {1'b1, CH_DQUOTE};
            CH_QMARK:     r = {1'b1, CH_QMARK};
            default:      r = 9'd0;
        endcase
        return r;
    endfunction

    // Any character counts as a hex digit; non-hex letters wrap in 4 bits
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] u;
        logic [7:0] d;
        d = c - CH_ZERO;
        u = (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - CASE_OFFSET : c;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            return d[3:0];
        end
        return u[3:0] + HEX_ADJ;
    endfunction

endpackage

/* sv/sed_front.sv */
// Front end of the string escape decoder: classifies each accepted item,
// keeps the escape state and forms the results it causes.
// Depends on sed_pkg.
module sed_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_ch,
    input  logic          i_end_of_input,
    output logic          o_push,
    output sed_pkg::t_pair o_pair
);

    sed_pkg::t_mode r_mode, n_mode;
    logic [7:0]     r_accum, n_accum;
    logic [1:0]     r_count, n_count;
    logic           w_emit;
    logic [8:0]     w_simple;
    logic [7:0]     w_oct_d;
    logic           w_is_oct;
    logic           w_is_close;
    logic           w_is_bs;
    logic [1:0]     w_count_inc;

    always_comb begin
        w_simple    = sed_pkg::simple_escape(i_ch);
        w_oct_d     = i_ch - sed_pkg::CH_ZERO;
        w_is_oct    = (i_ch >= sed_pkg::CH_ZERO) && (i_ch <= sed_pkg::CH_SEVEN);
        w_is_close  = (i_ch == sed_pkg::CH_DQUOTE) || (i_ch == sed_pkg::CH_NUL);
        w_is_bs     = (i_ch == sed_pkg::CH_BACKSLASH);
        w_count_inc = r_count + 2'd1;

        n_mode  = r_mode;
        n_accum = r_accum;
        n_count = r_count;
        w_emit  = 1'b0;
        o_pair  = '0;
        o_pair.first.kind  = sed_pkg::KIND_DATA;
        o_pair.second.kind = sed_pkg::KIND_DATA;

        if (i_end_of_input) begin
            w_emit = 1'b1;
            o_pair.first.kind = sed_pkg::KIND_ERROR;
            n_mode  = sed_pkg::MODE_PLAIN;
            n_accum = '0;
            n_count = '0;
        end else begin
            case (r_mode)
                sed_pkg::MODE_ESC: begin
                    if (w_simple[8]) begin
                        w_emit = 1'b1;
                        o_pair.first.out_byte = w_simple[7:0];
                        n_mode = sed_pkg::MODE_PLAIN;
                    end else if (w_is_oct) begin
                        n_accum = w_oct_d;
                        n_count = 2'd1;
                        n_mode  = sed_pkg::MODE_OCT;
                    end else if (i_ch == sed_pkg::CH_LOWER_X) begin
                        n_accum = '0;
                        n_count = '0;
                        n_mode  = sed_pkg::MODE_HEX;
                    end else begin
                        n_mode = sed_pkg::MODE_PLAIN;
                    end
                end
                sed_pkg::MODE_OCT: begin
                    if (w_is_oct) begin
                        n_accum = {r_accum[4:0], 3'b000} + w_oct_d;
                        n_count = w_count_inc;
                        if (w_count_inc == sed_pkg::OCT_MAX_DIGITS) begin
                            w_emit = 1'b1;
                            o_pair.first.out_byte = n_accum;
                            n_mode  = sed_pkg::MODE_PLAIN;
                            n_accum = '0;
                            n_count = '0;
                        end
                    end else begin
                        // Emit the short run, then treat this character as plain text
                        w_emit = 1'b1;
                        o_pair.first.out_byte = r_accum;
                        n_mode  = sed_pkg::MODE_PLAIN;
                        n_accum = '0;
                        n_count = '0;
                        if (w_is_close) begin
                            o_pair.has_second  = 1'b1;
                            o_pair.second.kind = sed_pkg::KIND_CLOSED;
                        end else if (w_is_bs) begin
                            n_mode = sed_pkg::MODE_ESC;
                        end else begin
                            o_pair.has_second      = 1'b1;
                            o_pair.second.out_byte = i_ch;
                        end
                    end
                end
                sed_pkg::MODE_HEX: begin
                    n_accum = {r_accum[3:0], sed_pkg::hex_value(i_ch)};
                    if (r_count == sed_pkg::HEX_LAST_DIGIT) begin
                        w_emit = 1'b1;
                        o_pair.first.out_byte = n_accum;
                        n_mode  = sed_pkg::MODE_PLAIN;
                        n_accum = '0;
                        n_count = '0;
                    end else begin
                        n_count = w_count_inc;
                    end
                end
                default: begin
                    n_mode = sed_pkg::MODE_PLAIN;
                    if (w_is_close) begin
                        w_emit = 1'b1;
                        o_pair.first.kind = sed_pkg::KIND_CLOSED;
                        n_accum = '0;
                        n_count = '0;
                    end else if (w_is_bs) begin
                        n_mode = sed_pkg::MODE_ESC;
                    end else begin
                        w_emit = 1'b1;
                        o_pair.first.out_byte = i_ch;
                    end
                end
            endcase
        end
    end

    assign o_push = i_accept && w_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= sed_pkg::MODE_PLAIN;
            r_accum <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_accum <= n_accum;
            r_count <= n_count;
        end
    end

endmodule

/* sv/sed_queue.sv */
// Short result queue between front and back of the string escape decoder.
// Holds one entry per item that caused results. Depends on sed_pkg.
module sed_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  sed_pkg::t_pair       i_pair,
    input  logic                 i_pop,
    output sed_pkg::t_pair       o_head,
    output sed_pkg::t_q_status   o_status
);

    sed_pkg::t_pair                r_mem [sed_pkg::Q_DEPTH];
    logic [sed_pkg::Q_PTR_W-1:0]   r_wr;
    logic [sed_pkg::Q_PTR_W-1:0]   r_rd;
    logic [sed_pkg::Q_CNT_W-1:0]   r_count;

    assign o_head          = r_mem[r_rd];
    assign o_status.count  = r_count;
    assign o_status.empty  = (r_count == '0);
    assign o_status.full   = (r_count == sed_pkg::Q_CNT_W'(sed_pkg::Q_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* sv/sed_back.sv */
// Back end of the string escape decoder: unpacks queue entries into
// single results and holds them in the output register. Depends on sed_pkg.
module sed_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sed_pkg::t_pair i_head,
    input  logic           i_head_valid,
    output logic           o_pop,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic [7:0]     o_out_byte,
    output logic [1:0]     o_kind,
    output logic           o_last
);

    logic            r_valid;
    logic            r_pend;
    sed_pkg::t_result r_pend_res;
    sed_pkg::t_result r_res;
    logic            r_last;
    logic            w_load;

    assign w_load = !r_valid || i_out_ready;
    assign o_pop  = w_load && !r_pend && i_head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (w_load) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else begin
                r_valid <= i_head_valid;
                r_pend  <= i_head_valid && i_head.has_second;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_pend) begin
                r_res  <= r_pend_res;
                r_last <= 1'b1;
            end else begin
                r_res      <= i_head.first;
                r_last     <= !i_head.has_second;
                r_pend_res <= i_head.second;
            end
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_byte  = r_res.out_byte;
    assign o_kind      = r_res.kind;
    assign o_last      = r_last;

endmodule

/* sv/string_escape_decoder.sv */
// Top level of the string escape decoder: front end, result queue, back end.
// Depends on sed_pkg, sed_front, sed_queue and sed_back.
//
// Decodes the body of a C-style string literal, one raw character per input
// item, starting after the opening quote. Each item yields zero, one or two
// results (o_kind: data byte, string closed, or unterminated error); o_last
// marks the final result of an item. Simple escapes, one to three octal
// digits (truncated to 8 bits) and exactly two hex digits after 'x' are
// decoded; an unknown escape is dropped together with its backslash. A
// double quote or a zero byte closes the string; i_end_of_input raises the
// error result and discards any partial escape. After a close or an error
// the decoder starts afresh on the next literal. Rate: one item is accepted
// per cycle while the four-entry result queue has room; the queue entry of
// an item holds all its results, and the output register presents one result
// per cycle while i_out_ready is high, so an item that ends an octal run
// early with a character that gives its own result presents its two results
// in turn. The queue entry is written when the item is accepted and is then
// moved into the output register, which drives the outputs. No clearing pass
// is needed after reset.
module string_escape_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_ch,
    input  logic       i_end_of_input,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_kind,
    output logic       o_last
);

    logic                w_accept;
    logic                w_push;
    logic                w_pop;
    sed_pkg::t_pair      w_pair;
    sed_pkg::t_pair      w_head;
    sed_pkg::t_q_status  w_q_status;

    // Accept whenever the queue can take one more entry
    assign o_in_ready = !w_q_status.full;
    assign w_accept   = i_in_valid && o_in_ready;

    sed_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_ch           (i_ch),
        .i_end_of_input (i_end_of_input),
        .o_push         (w_push),
        .o_pair         (w_pair)
    );

    sed_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_pair   (w_pair),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    // Drain the queue one result per cycle into the output register whenever it is empty or being taken
    sed_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_head_valid (!w_q_status.empty),
        .o_pop        (w_pop),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_out_byte   (o_out_byte),
        .o_kind       (o_kind),
        .o_last       (o_last)
    );

    // An error ends every item that causes it
    a_error_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == sed_pkg::KIND_ERROR) |-> o_last)
        else $error("error result not marked last");

    // Close and error results carry a zero byte
    a_ctrl_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != sed_pkg::KIND_DATA) |-> (o_out_byte == 8'd0))
        else $error("non-data result with non-zero byte");

    // Only the decoded octal byte can be followed by another result
    a_first_is_data : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (o_kind == sed_pkg::KIND_DATA))
        else $error("non-last result is not a data byte");

    // Queue occupancy stays within its depth
    a_q_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_status.count <= sed_pkg::Q_CNT_W'(sed_pkg::Q_DEPTH))
        else $error("result queue overflow");

endmodule
